// ===== design/hslc_pkg.sv =====
// hslc_pkg: shared constants, types and helpers for the HSL to RGB converter.
// No dependencies; imported by hslc_chan and hsl_to_rgb_convert_top.
`default_nettype none

package hslc_pkg;

  // Field widths
  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned LevelW = 8;

  // Intermediate widths: levels reach 10000, ramp weight reaches 60,
  // ramp reaches 600000, scaled ramp reaches 159375
  localparam int unsigned LvlW    = 14;
  localparam int unsigned WeightW = 6;
  localparam int unsigned RampW   = 20;
  localparam int unsigned ScaledW = 18;

  // Numeric constants
  localparam logic [HueW-1:0]    HueFull   = 9'd360;
  localparam logic [PctW-1:0]    PctFull   = 7'd100;
  localparam logic [PctW-1:0]    LightHalf = 7'd50;
  localparam logic [WeightW-1:0] WeightTop = 6'd60;

  // 255/600000 reduces to 17/40000; 40000 = 64 * 625.
  // Divide by 625 as multiply by ceil(2^28/625), exact for inputs below 2^18.
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipW     = 19;
  localparam logic [RecipW-1:0] RecipMul = 19'd429497;
  localparam int unsigned PreShift   = 6;

  // Per-stage load strobes for one color channel
  typedef struct packed {
    logic ramp;
    logic scale;
    logic level;
  } hslc_load_t;

  // Weight of the (high - low) span at hue position pos (0..359)
  function automatic logic [WeightW-1:0] ramp_weight(input logic [HueW-1:0] pos);
    logic [HueW-1:0] fall;
    fall = 9'd240 - pos;
    if (pos < 9'd60) begin
      ramp_weight = pos[WeightW-1:0];
    end else if (pos < 9'd180) begin
      ramp_weight = WeightTop;
    end else if (pos < 9'd240) begin
      ramp_weight = fall[WeightW-1:0];
    end else begin
      ramp_weight = '0;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/hsl_to_rgb_convert_top.sv =====
// Structure: five register stages, stages 1 and 2 here and stages 3 to 5 in each
// hslc_chan. Throughput: one word per cycle while out_ready_i is high; stages stall
// independently so bubbles fill while the output waits.
// Reset: rst_ni is asynchronous active low and clears all stage valid bits;
// payload registers are not reset.
// hsl_to_rgb_convert_top: clamp/wrap, level and weight stage, three channels.
// Depends on hslc_pkg and hslc_chan.
`default_nettype none

module hsl_to_rgb_convert_top
  import hslc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [HueW-1:0]   hue_deg_i,
  input  wire logic [PctW-1:0]   sat_pct_i,
  input  wire logic [PctW-1:0]   light_pct_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [LevelW-1:0] red_level_o,
  output logic      [LevelW-1:0] green_level_o,
  output logic      [LevelW-1:0] blue_level_o
);

  // Stage valid bits and enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  hslc_load_t load;

  // Stage 1 payload
  logic [HueW-1:0] hue_d, hue_q;
  logic [PctW-1:0] sat_d, sat_q, light_d, light_q;

  // Stage 2 payload
  logic [LvlW-1:0]    high_d, high_q, low_d, low_q;
  logic [WeightW-1:0] wr_d, wr_q, wg_d, wg_q, wb_d, wb_q;
  logic [HueW-1:0]    pos_r, pos_b;
  logic [LvlW:0]      high_dark, high_bright, sum_x100, prod_sl, light_x200;

  // Stall chain: a stage advances when empty or when the next one advances
  always_comb begin
    en5 = !v5_q || out_ready_i;
    en4 = !v4_q || en5;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
    load.ramp  = en3 && v2_q;
    load.scale = en4 && v3_q;
    load.level = en5 && v4_q;
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v5_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Wrap hue into 0..359, clamp percentages to 100
  always_comb begin
    hue_d   = (hue_deg_i >= HueFull) ? hue_deg_i - HueFull : hue_deg_i;
    sat_d   = (sat_pct_i > PctFull) ? PctFull : sat_pct_i;
    light_d = (light_pct_i > PctFull) ? PctFull : light_pct_i;
  end

  // Form high and low levels (scaled by 10000) and the three ramp weights
  always_comb begin
    high_dark   = (LvlW+1)'(light_q) * ((LvlW+1)'(PctFull) + (LvlW+1)'(sat_q));
    sum_x100    = ((LvlW+1)'(light_q) + (LvlW+1)'(sat_q)) * (LvlW+1)'(PctFull);
    prod_sl     = (LvlW+1)'(sat_q) * (LvlW+1)'(light_q);
    high_bright = sum_x100 - prod_sl;
    high_d      = (light_q < LightHalf) ? high_dark[LvlW-1:0] : high_bright[LvlW-1:0];
    light_x200  = (LvlW+1)'(light_q) * (LvlW+1)'(200);
    low_d       = LvlW'(light_x200 - (LvlW+1)'(high_d));
    pos_r = (hue_q < 9'd240) ? hue_q + 9'd120 : hue_q - 9'd240;
    pos_b = (hue_q >= 9'd120) ? hue_q - 9'd120 : hue_q + 9'd240;
    wr_d  = ramp_weight(pos_r);
    wg_d  = ramp_weight(hue_q);
    wb_d  = ramp_weight(pos_b);
  end

  // Payload registers of stages 1 and 2
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      light_q <= light_d;
    end
    if (en2 && v1_q) begin
      high_q <= high_d;
      low_q  <= low_d;
      wr_q   <= wr_d;
      wg_q   <= wg_d;
      wb_q   <= wb_d;
    end
  end

  // Channel pipelines: stages 3 to 5
  hslc_chan u_red (
    .clk_i   (clk_i),
    .load_i  (load),
    .low_i   (low_q),
    .high_i  (high_q),
    .weight_i(wr_q),
    .level_o (red_level_o)
  );

  hslc_chan u_green (
    .clk_i   (clk_i),
    .load_i  (load),
    .low_i   (low_q),
    .high_i  (high_q),
    .weight_i(wg_q),
    .level_o (green_level_o)
  );

  hslc_chan u_blue (
    .clk_i   (clk_i),
    .load_i  (load),
    .low_i   (low_q),
    .high_i  (high_q),
    .weight_i(wb_q),
    .level_o (blue_level_o)
  );

  // Low level never exceeds high level
  a_low_le_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (low_q <= high_q))
    else $error("low level above high level");

  // High level bounded by 100*100
  a_high_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (high_q <= 14'd10000))
    else $error("high level out of range");

  // Ramp weights stay within 0..60
  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (wr_q <= WeightTop && wg_q <= WeightTop && wb_q <= WeightTop))
    else $error("ramp weight out of range");

  // An empty first stage always takes a word
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_ready_o)
    else $error("input stalled with empty first stage");

  // An accepted word occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word lost at first stage");

endmodule

`default_nettype wire

// ===== design/hslc_chan.sv =====
// hslc_chan: one color channel, ramp evaluation and scaling to an 8-bit level.
// Three register stages; depends on hslc_pkg.
`default_nettype none

module hslc_chan
  import hslc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire hslc_load_t         load_i,
  input  wire logic [LvlW-1:0]    low_i,
  input  wire logic [LvlW-1:0]    high_i,
  input  wire logic [WeightW-1:0] weight_i,
  output logic      [LevelW-1:0]  level_o
);

  logic [LvlW-1:0]         span;
  logic [RampW-1:0]        ramp_d, ramp_q;
  logic [RampW+4:0]        ramp_x17;
  logic [ScaledW-1:0]      scaled_d, scaled_q;
  logic [ScaledW+RecipW-1:0] prod;
  logic [LevelW-1:0]       level_d, level_q;

  // Ramp value: low*60 + span*weight
  always_comb begin
    span   = high_i - low_i;
    ramp_d = RampW'(low_i * RampW'(WeightTop)) + RampW'(span) * RampW'(weight_i);
  end

  // Multiply by 17 and drop the power-of-two part of 40000
  always_comb begin
    ramp_x17 = (RampW+5)'(ramp_q) * (RampW+5)'(17);
    scaled_d = ScaledW'(ramp_x17 >> PreShift);
  end

  // Divide by 625 via reciprocal
  always_comb begin
    prod    = (ScaledW+RecipW)'(scaled_q) * (ScaledW+RecipW)'(RecipMul);
    level_d = prod[RecipShift +: LevelW];
  end

  // Hold each stage unless its load strobe is set
  always_ff @(posedge clk_i) begin
    if (load_i.ramp) begin
      ramp_q <= ramp_d;
    end
    if (load_i.scale) begin
      scaled_q <= scaled_d;
    end
    if (load_i.level) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

`default_nettype wire
